FILE: rtl/tesp_pkg.sv
// ----------------------------------------------------------------------------
// Timed event sequence player package
// Shared types, constants and helper functions of the sequence player.
// ----------------------------------------------------------------------------
`default_nettype none
package tesp_pkg;

	localparam int ENTRIES = 1024;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int TIME_W  = 47;
	localparam int FRM_W   = 11;
	localparam int VAL_W   = 32;
	localparam int STEP_W  = 32;
	localparam int RATE_W  = 16;
	localparam int PROD_W  = STEP_W + RATE_W;
	localparam int RATE_FRAC = 12;

	localparam logic [1:0] CFG_FRAMES = 2'd0;
	localparam logic [1:0] CFG_STEP   = 2'd1;
	localparam logic [1:0] CFG_LOOP   = 2'd2;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic              req_type;
		logic [9:0]        entry_index;
		logic [46:0]       entry_duration;
		logic [31:0]       entry_value_a;
		logic [31:0]       entry_value_b;
		logic [15:0]       rate;
		logic              trig;
		logic signed [47:0] seek_time;
	} req_t;

	typedef struct packed {
		logic [31:0] out_value_a;
		logic [31:0] out_value_b;
		logic        play_done;
		logic [9:0]  current_entry;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] duration;
		logic [VAL_W-1:0]  value_a;
		logic [VAL_W-1:0]  value_b;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TMAX : s[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

	function automatic logic [IDX_W:0] frames_eff(input logic [FRM_W-1:0] f);
		logic [IDX_W:0] r;
		if (f == '0) begin
			r = (IDX_W+1)'(1);
		end else if (32'(f) > ENTRIES) begin
			r = (IDX_W+1)'(ENTRIES);
		end else begin
			r = (IDX_W+1)'(f);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/tesp_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying table writes and playback ticks.
// ----------------------------------------------------------------------------
`default_nettype none
interface tesp_req_if;
	import tesp_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tesp_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one playback result per tick.
// ----------------------------------------------------------------------------
`default_nettype none
interface tesp_rsp_if;
	import tesp_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tesp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tesp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/timed_event_sequence_player_core.sv
// A table write is stored when it is accepted. A tick walks the sequencer states, and a seek
// steps back or forward one entry at a time; the result may also wait for the sink. Every
// table read passes through the shared read port and a fetch state.
// One item is in work at a time; the result waits in an output register.
// Reset is asynchronous and active low; it clears control state and loads register defaults.
// The table itself is not cleared; an entry must be written before it is read.
// ----------------------------------------------------------------------------
// Timed event sequence player core
// Plays a table of timed entries, one result per tick, with seek and loop.
// ----------------------------------------------------------------------------
`default_nettype none
module timed_event_sequence_player_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [31:0]                cfg_wdata,
	tesp_req_if.sink                        req,
	tesp_rsp_if.source                      rsp
);
	import tesp_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_FETCH   = 4'd1;
	localparam logic [3:0] ST_REARM   = 4'd2;
	localparam logic [3:0] ST_SEEK    = 4'd3;
	localparam logic [3:0] ST_BACK    = 4'd4;
	localparam logic [3:0] ST_FWD     = 4'd5;
	localparam logic [3:0] ST_FWDADD  = 4'd6;
	localparam logic [3:0] ST_SHOW    = 4'd7;
	localparam logic [3:0] ST_MUL     = 4'd8;
	localparam logic [3:0] ST_ADD     = 4'd9;
	localparam logic [3:0] ST_NEXT    = 4'd10;
	localparam logic [3:0] ST_LOOP    = 4'd11;

	logic [3:0]         state_q, ret_q;
	logic [FRM_W-1:0]   frames_q;
	logic [STEP_W-1:0]  step_q;
	logic               loop_q;
	logic [TIME_W-1:0]  time_q, bnd_q;
	logic [IDX_W-1:0]   idx_q, rd_addr_q;
	logic               done_q, prev_trig_q, changed_q, seek_pend_q;
	logic [RATE_W-1:0]  rate_q;
	logic [47:0]        seek_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	rsp_t               out_q;

	entry_t             rd_entry;
	logic [ENTRY_W-1:0] rdata;
	logic               wr_en, tick_acc, slot_free;
	logic [IDX_W:0]     frames, idx_inc;
	logic [TIME_W-1:0]  seek_raw, back, t_new;
	entry_t             wr_entry;

	assign rd_entry  = entry_t'(rdata);
	assign frames    = frames_eff(frames_q);
	assign idx_inc   = {1'b0, idx_q} + (IDX_W+1)'(1);
	assign seek_raw  = seek_q[TIME_W-1:0];
	assign back      = sat_sub(bnd_q, rd_entry.duration);
	assign t_new     = sat_add(time_q, TIME_W'(prod_q >> RATE_FRAC));
	assign slot_free = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == ST_IDLE);
	assign wr_en     = req.valid && req.ready && (req.data.req_type == REQ_WRITE)
		&& ({1'b0, req.data.entry_index} < 11'(ENTRIES));
	assign tick_acc  = req.valid && req.ready && (req.data.req_type == REQ_TICK);

	assign wr_entry.duration = req.data.entry_duration;
	assign wr_entry.value_a  = req.data.entry_value_a;
	assign wr_entry.value_b  = req.data.entry_value_b;

	tesp_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (req.data.entry_index[IDX_W-1:0]),
		.wdata (wr_entry),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= 11'd1024;
			step_q   <= 32'd89478;
			loop_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAMES: frames_q <= cfg_wdata[FRM_W-1:0];
				CFG_STEP:   step_q   <= cfg_wdata;
				CFG_LOOP:   loop_q   <= cfg_wdata[0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			rate_q <= req.data.rate;
			seek_q <= req.data.seek_time;
		end
		if (state_q == ST_MUL) begin
			prod_q <= step_q * rate_q;
		end
		if (state_q == ST_SHOW && slot_free) begin
			out_q.out_value_a   <= (rate_q != '0 && !done_q) ? rd_entry.value_a : '0;
			out_q.out_value_b   <= (rate_q != '0 && !done_q) ? rd_entry.value_b : '0;
			out_q.play_done     <= done_q;
			out_q.current_entry <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			time_q      <= '0;
			bnd_q       <= '0;
			idx_q       <= '0;
			rd_addr_q   <= '0;
			done_q      <= 1'b0;
			prev_trig_q <= 1'b0;
			changed_q   <= 1'b1;
			seek_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SHOW && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (wr_en) begin
						changed_q <= 1'b1;
					end
					if (tick_acc) begin
						prev_trig_q <= req.data.trig;
						seek_pend_q <= req.data.trig && !prev_trig_q;
						if (changed_q) begin
							changed_q <= 1'b0;
							rd_addr_q <= '0;
							ret_q     <= ST_REARM;
							state_q   <= ST_FETCH;
						end else if (req.data.trig && !prev_trig_q) begin
							state_q <= ST_SEEK;
						end else begin
							rd_addr_q <= idx_q;
							ret_q     <= ST_SHOW;
							state_q   <= ST_FETCH;
						end
					end
				end
				ST_FETCH: state_q <= ret_q;
				ST_REARM: begin
					idx_q  <= '0;
					time_q <= '0;
					bnd_q  <= rd_entry.duration;
					done_q <= (rd_entry.duration == '0);
					if (seek_pend_q) begin
						state_q <= ST_SEEK;
					end else begin
						rd_addr_q <= '0;
						ret_q     <= ST_SHOW;
						state_q   <= ST_FETCH;
					end
				end
				ST_SEEK: begin
					seek_pend_q <= 1'b0;
					done_q      <= 1'b0;
					if (seek_q[47] || seek_q == '0) begin
						rd_addr_q <= '0;
						ret_q     <= ST_REARM;
						state_q   <= ST_FETCH;
					end else if (bnd_q > seek_raw) begin
						time_q    <= seek_raw;
						rd_addr_q <= idx_q;
						ret_q     <= ST_BACK;
						state_q   <= ST_FETCH;
					end else begin
						time_q  <= seek_raw;
						state_q <= ST_FWD;
					end
				end
				ST_BACK: begin
					state_q <= ST_FETCH;
					if (back <= seek_raw || idx_q == '0) begin
						rd_addr_q <= idx_q;
						ret_q     <= ST_SHOW;
					end else begin
						bnd_q     <= back;
						idx_q     <= idx_q - IDX_W'(1);
						rd_addr_q <= idx_q - IDX_W'(1);
						ret_q     <= ST_BACK;
					end
				end
				ST_FWD: begin
					state_q <= ST_FETCH;
					if (bnd_q >= seek_raw) begin
						rd_addr_q <= idx_q;
						ret_q     <= ST_SHOW;
					end else if (idx_inc >= frames) begin
						done_q    <= 1'b1;
						time_q    <= bnd_q;
						idx_q     <= IDX_W'(frames - 1'b1);
						rd_addr_q <= IDX_W'(frames - 1'b1);
						ret_q     <= ST_SHOW;
					end else begin
						idx_q     <= idx_inc[IDX_W-1:0];
						rd_addr_q <= idx_inc[IDX_W-1:0];
						ret_q     <= ST_FWDADD;
					end
				end
				ST_FWDADD: begin
					bnd_q   <= sat_add(bnd_q, rd_entry.duration);
					state_q <= ST_FWD;
				end
				ST_SHOW: begin
					if (slot_free) begin
						state_q <= done_q ? ST_IDLE : ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					if (t_new >= bnd_q && idx_inc < frames) begin
						time_q    <= t_new;
						idx_q     <= idx_inc[IDX_W-1:0];
						rd_addr_q <= idx_inc[IDX_W-1:0];
						ret_q     <= ST_NEXT;
						state_q   <= ST_FETCH;
					end else if (t_new >= bnd_q && loop_q) begin
						time_q    <= t_new;
						rd_addr_q <= '0;
						ret_q     <= ST_LOOP;
						state_q   <= ST_FETCH;
					end else if (t_new >= bnd_q) begin
						done_q  <= 1'b1;
						time_q  <= bnd_q;
						idx_q   <= IDX_W'(frames - 1'b1);
						state_q <= ST_IDLE;
					end else begin
						time_q  <= t_new;
						state_q <= ST_IDLE;
					end
				end
				ST_NEXT: begin
					bnd_q   <= sat_add(bnd_q, rd_entry.duration);
					state_q <= ST_IDLE;
				end
				ST_LOOP: begin
					idx_q   <= '0;
					time_q  <= '0;
					bnd_q   <= rd_entry.duration;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.play_done |->
		rsp.data.out_value_a == '0 && rsp.data.out_value_b == '0)
		else $error("done result carries nonzero values");

	a_fetch_moves: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |=> state_q != ST_FETCH && state_q != ST_IDLE)
		else $error("table fetch did not hand over to its consumer");

	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> changed_q)
		else $error("table write did not mark the table changed");

endmodule
`default_nettype wire
